### hw/rtl/line_fixed_string_matcher_core_defines.svh
// Assertion macros used by the line matcher core RTL.
`ifndef LINE_FIXED_STRING_MATCHER_CORE_DEFINES_SVH
`define LINE_FIXED_STRING_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define LFSM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define LFSM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lfsm_pkg.sv
// Types and constants of the line fixed-string matcher.
package lfsm_pkg;

    localparam int PatternBytes = 16;
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_PATTERN_LOW    = 2'd0;
    localparam t_cfg_index CFG_PATTERN_HIGH   = 2'd1;
    localparam t_cfg_index CFG_PATTERN_LENGTH = 2'd2;

    typedef logic [PatternBytes-1:0][7:0] t_pattern;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic        line_matched;
        logic [15:0] line_length;
        logic        final_unterminated;
    } t_result;

endpackage

### hw/rtl/lfsm_chan_if.sv
// Valid/ready channel carrying one request payload.
interface lfsm_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/lfsm_cell.sv
// One window cell: holds one recent byte and compares its incoming byte with the pattern.
module lfsm_cell #(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [7:0]        i_byte,
    input  lfsm_pkg::t_pattern i_pattern,
    input  logic [4:0]        i_plen,
    output logic [7:0]        o_byte,
    output logic              o_ok
);
    localparam logic [4:0] CellIdx = 5'(INDEX);

    logic [7:0] r_byte;
    logic [4:0] w_sel;

    // The newest byte sits in cell 0 and meets the last pattern byte.
    assign w_sel = i_plen - 5'd1 - CellIdx;
    assign o_ok  = (CellIdx >= i_plen) || (i_byte == i_pattern[w_sel[3:0]]);
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end
endmodule

### hw/rtl/lfsm_out_buf.sv
// Two-entry output buffer: output register plus skid register.
module lfsm_out_buf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  lfsm_pkg::t_result      i_result,
    output logic                   o_ready,
    lfsm_chan_if.source            o_out
);
    logic              r_out_valid;
    logic              r_skid_valid;
    lfsm_pkg::t_result r_out;
    lfsm_pkg::t_result r_skid;
    logic              w_pop;

    assign w_pop         = r_out_valid && o_out.ready;
    assign o_ready       = !r_skid_valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // No push can arrive while the skid register is full.
            if (w_pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out       <= i_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_result;
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end
endmodule

### hw/rtl/line_fixed_string_matcher_core.sv
// Top level of the line fixed-string matcher.
// Usage: bytes arrive one per request on i_in (data_byte, end_of_stream). A newline
// closes the current line and yields one request on o_out with the verdict, the line
// length (saturating at 65535) and final_unterminated clear. An end-of-stream request
// flushes a non-empty unterminated line with final_unterminated set; an empty one
// gives nothing. Either way the line state is cleared.
// Throughput is one byte per cycle unless i_in is stalled: a row of MAX_PATTERN cells
// shifts the newest bytes along and compares all of them with the pattern in the same
// cycle. A result is registered in the output register, or in the skid register while
// the output register is held. i_in.ready drops only when both hold a result, so
// input continues while one result waits to be taken. The pattern is to be written
// through i_cfg_we / i_cfg_index / i_cfg_data only while idle; the block does not
// enforce this. Reset (synchronous, active low) clears the pattern registers, the
// line count, the match flag and the output buffer; no clearing pass is needed.
`include "line_fixed_string_matcher_core_defines.svh"
module line_fixed_string_matcher_core #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    lfsm_chan_if.sink              i_in,
    lfsm_chan_if.source            o_out,
    input  logic                   i_cfg_we,
    input  lfsm_pkg::t_cfg_index   i_cfg_index,
    input  logic [63:0]            i_cfg_data
);
    lfsm_pkg::t_pattern r_pattern;
    logic [4:0]         r_plen;
    logic [15:0]        r_line_count;
    logic               r_line_hit;

    logic [15:0]        n_line_count;
    logic               n_line_hit;
    logic [4:0]         w_plen;
    logic               w_accept;
    logic               w_newline;
    logic               w_shift;
    logic               w_buf_ready;
    logic               w_push;
    lfsm_pkg::t_result  w_result;
    lfsm_pkg::t_in_item w_item;
    logic [MAX_PATTERN-1:0]      w_ok;
    logic [MAX_PATTERN-1:0][7:0] w_window;

    assign w_item    = i_in.payload;
    assign i_in.ready = w_buf_ready;
    assign w_accept  = i_in.valid && w_buf_ready;
    assign w_newline = !w_item.end_of_stream && (w_item.data_byte == lfsm_pkg::NEWLINE_BYTE);
    assign w_shift   = w_accept && !w_item.end_of_stream && !w_newline;

    assign w_plen = (r_plen > 5'(MAX_PATTERN)) ? 5'(MAX_PATTERN) : r_plen;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        lfsm_cell #(.INDEX(k)) u_cell (
            .i_clk     (i_clk),
            .i_shift   (w_shift),
            .i_byte    ((k == 0) ? w_item.data_byte : w_window[(k == 0) ? 0 : k - 1]),
            .i_pattern (r_pattern),
            .i_plen    (w_plen),
            .o_byte    (w_window[k]),
            .o_ok      (w_ok[k])
        );
    end

    assign n_line_count = (r_line_count == lfsm_pkg::LEN_MAX) ? r_line_count
                                                              : r_line_count + 16'd1;
    // Short lines never match, so stale window bytes are never seen.
    assign n_line_hit = r_line_hit || ((w_plen != 5'd0) && (n_line_count >= 16'(w_plen))
                                       && (&w_ok));

    assign w_push = w_accept && (w_newline ||
                                 (w_item.end_of_stream && (r_line_count != 16'd0)));
    assign w_result.line_matched       = r_line_hit || (w_plen == 5'd0);
    assign w_result.line_length        = r_line_count;
    assign w_result.final_unterminated = w_item.end_of_stream;

    lfsm_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .o_ready  (w_buf_ready),
        .o_out    (o_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= '0;
            r_plen       <= 5'd0;
            r_line_count <= 16'd0;
            r_line_hit   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lfsm_pkg::CFG_PATTERN_LOW:    r_pattern[7:0]  <= i_cfg_data;
                    lfsm_pkg::CFG_PATTERN_HIGH:   r_pattern[15:8] <= i_cfg_data;
                    lfsm_pkg::CFG_PATTERN_LENGTH: r_plen          <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                if (w_shift) begin
                    r_line_count <= n_line_count;
                    r_line_hit   <= n_line_hit;
                end else begin
                    r_line_count <= 16'd0;
                    r_line_hit   <= 1'b0;
                end
            end
        end
    end

    `LFSM_ASSERT_NOW(a_skid_implies_out, i_clk, i_rst_n, !w_buf_ready, o_out.valid,
        "skid register full while output register empty")
    `LFSM_ASSERT_NEXT(a_line_cleared, i_clk, i_rst_n, w_accept && !w_shift,
        (r_line_count == 16'd0) && !r_line_hit, "line state not cleared after line end")
    `LFSM_ASSERT_NOW(a_flush_nonempty, i_clk, i_rst_n,
        o_out.valid && o_out.payload.final_unterminated,
        o_out.payload.line_length != 16'd0, "empty unterminated line flushed")
endmodule

### tb/sv/line_fixed_string_matcher_core_tb.sv
// Self-checking testbench for the line fixed-string matcher core.
module line_fixed_string_matcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfsm_pkg::*;

    typedef enum logic [1:0] {ROW_BYTE, ROW_EOS, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [7:0] value;
        int         reps;
        t_cfg_index reg_sel;
        logic [63:0] reg_data;
        bit         typed;
        t_result    verdict;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_index  i_cfg_index;
    logic [63:0] i_cfg_data;

    lfsm_chan_if #(.t_payload(t_in_item)) in_ch ();
    lfsm_chan_if #(.t_payload(t_result))  out_ch ();

    line_fixed_string_matcher_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow of the pattern registers and of the line state.
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [4:0]  pat_len = '0;
    logic [PatternBytes-1:0][7:0] seen_bytes = '0;
    logic [15:0] open_len = '0;
    logic        open_hit = 1'b0;

    t_result verdicts_due[$];
    int      failures = 0;
    int      verdicts_seen = 0;
    int      items_sent = 0;
    int      settings_used = 0;
    bit      idle_on = 1'b1;
    logic [7:0] hot [3];
    bit      noisy = 1'b0;

    // Stimulus table; verdicts are typed in only where they are obvious.
    t_stim_row directed_plan [33] = '{
        '{ROW_BYTE, 8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b1, '{1'b1, 16'd0, 1'b0}},
        '{ROW_EOS,  8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h78, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_EOS,  8'hFF, 1, CFG_PATTERN_LOW, 64'h0, 1'b1, '{1'b1, 16'd1, 1'b1}},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LOW, 64'hFFFF_FFFF_FF61_6161, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LENGTH, 64'd3, 1'b0, '0},
        '{ROW_BYTE, 8'h61, 2, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h61, 4, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_EOS,  8'h61, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LENGTH, 64'd31, 1'b0, '0},
        '{ROW_BYTE, 8'hFF, 16, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LOW, 64'h0000_0000_0000_0A61, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LENGTH, 64'd2, 1'b0, '0},
        '{ROW_BYTE, 8'h61, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_HIGH, 64'h0, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LENGTH, 64'd1, 1'b0, '0},
        '{ROW_BYTE, 8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h00, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LOW, 64'h0000_0000_0000_7171, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LENGTH, 64'd2, 1'b0, '0},
        '{ROW_BYTE, 8'h71, 2, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_CFG,  8'h00, 1, CFG_PATTERN_LOW, 64'h0000_0000_0000_7A7A, 1'b0, '0},
        '{ROW_BYTE, 8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h79, 65540, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h7A, 2, CFG_PATTERN_LOW, 64'h0, 1'b0, '0},
        '{ROW_BYTE, 8'h0A, 1, CFG_PATTERN_LOW, 64'h0, 1'b1, '{1'b1, 16'hFFFF, 1'b0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("line_fixed_string_matcher_core regression: fail");
        $finish;
    end

    // Applies one request to the shadow state; returns 1 when a verdict is due.
    function automatic bit line_verdict(input t_in_item req, output t_result res);
        t_pattern pat;
        int       used;
        bit       tail_ok;
        pat  = {pat_hi, pat_lo};
        used = (pat_len > PatternBytes) ? PatternBytes : int'(pat_len);
        res.line_matched       = open_hit || (used == 0);
        res.line_length        = open_len;
        res.final_unterminated = req.end_of_stream;
        if (req.end_of_stream || req.data_byte == NEWLINE_BYTE) begin
            line_verdict = req.end_of_stream ? (open_len != 0) : 1'b1;
            seen_bytes = '0;
            open_len   = '0;
            open_hit   = 1'b0;
            return line_verdict;
        end
        seen_bytes = {seen_bytes[PatternBytes-2:0], req.data_byte};
        if (open_len != LEN_MAX)
            open_len++;
        if (used != 0 && int'(open_len) >= used) begin
            tail_ok = 1'b1;
            for (int k = 0; k < used; k++)
                if (seen_bytes[k] != pat[used-1-k])
                    tail_ok = 1'b0;
            if (tail_ok)
                open_hit = 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_item(input t_in_item req, input bit typed, input t_result typed_res);
        t_result guess;
        bit      due;
        if (idle_on && $urandom_range(0, 15) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.payload = req;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        due = line_verdict(req, guess);
        if (typed)
            verdicts_due.push_back(typed_res);
        else if (due)
            verdicts_due.push_back(guess);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drops valid and lets every outstanding verdict drain.
    task automatic settle();
        in_ch.valid = 1'b0;
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index sel, input logic [63:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = val;
        case (sel)
            CFG_PATTERN_LOW:    pat_lo = val;
            CFG_PATTERN_HIGH:   pat_hi = val;
            CFG_PATTERN_LENGTH: pat_len = val[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        if (noisy || $urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return hot[$urandom_range(0, 2)];
    endfunction

    task automatic new_setting();
        t_pattern pat;
        int       sel;
        for (int h = 0; h < 3; h++)
            hot[h] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'(8'h61 + h);
        noisy = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < PatternBytes; i++)
            pat[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : hot[$urandom_range(0, 2)];
        sel = $urandom_range(0, 9);
        if (sel == 0)
            pat = '0;
        else if (sel == 1)
            pat = '1;
        write_reg(CFG_PATTERN_LOW, pat[7:0]);
        write_reg(CFG_PATTERN_HIGH, pat[15:8]);
        case ($urandom_range(0, 9))
            0:       write_reg(CFG_PATTERN_LENGTH, 64'd0);
            1:       write_reg(CFG_PATTERN_LENGTH, 64'd16);
            2:       write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(17, 31)));
            default: write_reg(CFG_PATTERN_LENGTH, 64'($urandom_range(1, 16)));
        endcase
        settings_used++;
    endtask

    // One line of random text, often with the pattern planted somewhere in it.
    task automatic send_random_line();
        logic [7:0] text[$];
        t_pattern   pat;
        t_in_item   req;
        int         n;
        int         at;
        int         used;
        int         ending;
        pat  = {pat_hi, pat_lo};
        used = (pat_len > PatternBytes) ? PatternBytes : int'(pat_len);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 24);
        for (int k = 0; k < n; k++)
            text.push_back(pick_byte());
        if (used != 0 && $urandom_range(0, 1) == 1) begin
            at = $urandom_range(0, n);
            for (int k = 0; k < used; k++)
                text.insert(at + k, pat[k]);
        end
        foreach (text[k]) begin
            req.data_byte     = text[k];
            req.end_of_stream = 1'b0;
            send_item(req, 1'b0, '0);
        end
        ending = $urandom_range(0, 19);
        if (ending < 19) begin
            req.data_byte     = (ending < 16) ? NEWLINE_BYTE : 8'($urandom_range(0, 255));
            req.end_of_stream = (ending >= 16);
            send_item(req, 1'b0, '0);
            if (ending >= 16 && $urandom_range(0, 3) == 0)
                send_item(req, 1'b0, '0);
        end
    endtask

    // Receiver: random stall bursts while idling is on.
    initial begin : sink_side
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : verdict_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                $error("verdict with none expected: matched %0b length %0d final %0b",
                       out_ch.payload.line_matched, out_ch.payload.line_length,
                       out_ch.payload.final_unterminated);
                failures++;
            end else begin
                want = verdicts_due.pop_front();
                verdicts_seen++;
                if (out_ch.payload.line_matched !== want.line_matched) begin
                    $error("line_matched: expected %0b, got %0b",
                           want.line_matched, out_ch.payload.line_matched);
                    failures++;
                end
                if (out_ch.payload.line_length !== want.line_length) begin
                    $error("line_length: expected %0d, got %0d",
                           want.line_length, out_ch.payload.line_length);
                    failures++;
                end
                if (out_ch.payload.final_unterminated !== want.final_unterminated) begin
                    $error("final_unterminated: expected %0b, got %0b",
                           want.final_unterminated, out_ch.payload.final_unterminated);
                    failures++;
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row row;
        t_in_item  req;
        int        random_base;
        int        phase_goal;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_PATTERN_LOW;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_plan[r]) begin
            row = directed_plan[r];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.reg_sel, row.reg_data);
            end else begin
                for (int n = 0; n < row.reps; n++) begin
                    req.data_byte     = row.value;
                    req.end_of_stream = (row.kind == ROW_EOS);
                    send_item(req, row.typed && n == row.reps - 1, row.verdict);
                end
            end
        end

        // Phases may end mid-line, so a new pattern also lands part-way through a line.
        random_base = items_sent;
        while (items_sent - random_base < 1800) begin
            if (items_sent - random_base >= 1500)
                idle_on = 1'b0;
            settle();
            new_setting();
            phase_goal = items_sent + $urandom_range(100, 180);
            while (items_sent < phase_goal)
                send_random_line();
        end

        settle();
        $display("Sent %0d byte and end-of-stream requests and checked %0d line verdicts",
                 items_sent, verdicts_seen);
        $display("across %0d random pattern settings after the directed table.", settings_used);
        if (failures == 0)
            $display("line_fixed_string_matcher_core regression: pass");
        else
            $display("line_fixed_string_matcher_core regression: fail");
        $finish;
    end

endmodule
